// ===== src/ffa_pkg.sv =====
// Shared types and codes for the first-fit allocator with compaction.
// Used by ffa_engine, the core top level and ffa_checker.
`default_nettype none

package ffa_pkg;

  // Operation codes; the unused code behaves as a defragment
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ERASE   = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;
  localparam logic [1:0] OP_SPARE   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_ILLEGAL = 2'd2;

  // Configuration port
  localparam int          CFG_AW         = 3;
  localparam logic        REG_MEM_SIZE   = 1'b0;
  localparam logic [7:0]  MEM_SIZE_RESET = 8'd128;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  request_size;
    logic [15:0] block_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_id;
  } out_item_t;

  typedef struct packed {
    logic     start;
    in_item_t item;
  } ffa_cmd_t;

  typedef struct packed {
    logic idle;
    logic rsp_valid;
  } ffa_eng_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_ZERO,
    ST_RESP
  } ffa_state_t;

endpackage

`default_nettype wire

// ===== src/ffa_engine.sv =====
// Owner-map memory and the sequencer that scans, fills and compacts it.
// Depends on ffa_pkg for the item, command and state types.
`default_nettype none

module ffa_engine #(
  parameter int MEM_CELLS = 128,
  parameter int ID_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffa_pkg::ffa_cmd_t     cmd,
  input  logic [7:0]            mem_size,
  input  logic                  rsp_take,
  output ffa_pkg::ffa_eng_stat_t stat,
  output ffa_pkg::out_item_t    rsp
);

  localparam int AW = $clog2(MEM_CELLS);
  localparam int CW = $clog2(MEM_CELLS + 1);
  localparam int LW = (CW > 8) ? CW : 8;
  localparam int WW = (ID_BITS > 16) ? ID_BITS : 16;
  localparam logic [CW-1:0] CELLS = CW'(MEM_CELLS);

  logic [ID_BITS-1:0] map_mem [MEM_CELLS];

  ffa_pkg::ffa_state_t state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [ID_BITS-1:0]  rd_data_r;
  logic [CW-1:0]       run_r, run_nxt;
  logic [AW-1:0]       start_r, start_nxt;
  logic [AW-1:0]       end_r, end_nxt;
  logic [CW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic                hit_r, hit_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [7:0]          req_r, req_nxt;
  logic [15:0]         id_r, id_nxt;
  logic [ID_BITS-1:0]  next_id_r, next_id_nxt;
  logic [1:0]          rsp_status_r, rsp_status_nxt;
  logic [15:0]         rsp_id_r, rsp_id_nxt;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [ID_BITS-1:0]  mem_wdata;

  logic [LW-1:0]       mem_size_ext;
  logic [CW-1:0]       alloc_limit, scan_limit;
  logic                is_alloc, is_erase;
  logic                scan_issue, scan_end;
  logic                cell_free, alloc_hit, id_match;
  logic [CW-1:0]       run_inc;
  logic                early_fail;
  logic                fill_last, zero_last, clear_last;
  logic [WW-1:0]       next_id_ext;

  // Owner map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= map_mem[idx_r[AW-1:0]];
    end
  end

  assign mem_size_ext = LW'(mem_size);
  assign alloc_limit  = (mem_size_ext > LW'(MEM_CELLS)) ? CELLS : CW'(mem_size_ext);
  assign is_alloc     = (op_r == ffa_pkg::OP_ALLOC);
  assign is_erase     = (op_r == ffa_pkg::OP_ERASE);
  assign scan_limit   = is_alloc ? alloc_limit : CELLS;

  assign scan_issue = (state_r == ffa_pkg::ST_SCAN) && (idx_r < scan_limit);
  assign scan_end   = (state_r == ffa_pkg::ST_SCAN) && !rd_valid_r && (idx_r >= scan_limit);
  assign cell_free  = (rd_data_r == '0);
  assign run_inc    = run_r + CW'(1);
  assign alloc_hit  = (state_r == ffa_pkg::ST_SCAN) && rd_valid_r && is_alloc && cell_free &&
                      (LW'(run_inc) >= LW'(req_r));
  assign id_match   = rd_valid_r && (id_r != '0) && (WW'(rd_data_r) == WW'(id_r));

  assign early_fail = (cmd.item.operation == ffa_pkg::OP_ALLOC) &&
                      ((cmd.item.request_size == '0) || (next_id_r == '0));

  assign fill_last  = (idx_r[AW-1:0] == end_r);
  assign zero_last  = (wr_ptr_r == CELLS - CW'(1));
  assign clear_last = (idx_r == CELLS - CW'(1));
  assign next_id_ext = WW'(next_id_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffa_pkg::ST_CLEAR: begin
        if (clear_last) state_nxt = ffa_pkg::ST_IDLE;
      end
      ffa_pkg::ST_IDLE: begin
        if (cmd.start) state_nxt = early_fail ? ffa_pkg::ST_RESP : ffa_pkg::ST_SCAN;
      end
      ffa_pkg::ST_SCAN: begin
        if (alloc_hit) begin
          state_nxt = ffa_pkg::ST_FILL;
        end else if (scan_end) begin
          if (is_alloc) begin
            state_nxt = ffa_pkg::ST_RESP;
          end else if (is_erase) begin
            state_nxt = hit_r ? ffa_pkg::ST_IDLE : ffa_pkg::ST_RESP;
          end else begin
            state_nxt = (wr_ptr_r == CELLS) ? ffa_pkg::ST_IDLE : ffa_pkg::ST_ZERO;
          end
        end
      end
      ffa_pkg::ST_FILL: begin
        if (fill_last) state_nxt = ffa_pkg::ST_RESP;
      end
      ffa_pkg::ST_ZERO: begin
        if (zero_last) state_nxt = ffa_pkg::ST_IDLE;
      end
      ffa_pkg::ST_RESP: begin
        if (rsp_take) state_nxt = ffa_pkg::ST_IDLE;
      end
      default: state_nxt = ffa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_nxt        = idx_r;
    rd_valid_nxt   = 1'b0;
    rd_idx_nxt     = idx_r[AW-1:0];
    run_nxt        = run_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    wr_ptr_nxt     = wr_ptr_r;
    hit_nxt        = hit_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    id_nxt         = id_r;
    next_id_nxt    = next_id_r;
    rsp_status_nxt = rsp_status_r;
    rsp_id_nxt     = rsp_id_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = '0;

    unique case (state_r)
      ffa_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + CW'(1);
      end
      ffa_pkg::ST_IDLE: begin
        if (cmd.start) begin
          op_nxt     = cmd.item.operation;
          req_nxt    = cmd.item.request_size;
          id_nxt     = cmd.item.block_id;
          idx_nxt    = '0;
          run_nxt    = '0;
          hit_nxt    = 1'b0;
          wr_ptr_nxt = '0;
          if (early_fail) begin
            rsp_status_nxt = ffa_pkg::STAT_FAIL;
            rsp_id_nxt     = '0;
          end
        end
      end
      ffa_pkg::ST_SCAN: begin
        mem_re       = scan_issue;
        rd_valid_nxt = scan_issue;
        if (scan_issue) idx_nxt = idx_r + CW'(1);
        if (rd_valid_r) begin
          if (is_alloc) begin
            if (cell_free) begin
              run_nxt = run_inc;
              if (run_r == '0) start_nxt = rd_idx_r;
              if (alloc_hit) begin
                // restart the index at the head of the run for the fill
                idx_nxt = (run_r == '0) ? CW'(rd_idx_r) : CW'(start_r);
                end_nxt = rd_idx_r;
              end
            end else begin
              run_nxt = '0;
            end
          end else if (is_erase) begin
            if (id_match) begin
              mem_we    = 1'b1;
              mem_waddr = rd_idx_r;
              hit_nxt   = 1'b1;
            end
          end else begin
            // write pointer never passes the read pointer: no hazard
            if (!cell_free) begin
              mem_we     = 1'b1;
              mem_waddr  = wr_ptr_r[AW-1:0];
              mem_wdata  = rd_data_r;
              wr_ptr_nxt = wr_ptr_r + CW'(1);
            end
          end
        end
        if (scan_end) begin
          if (is_alloc) begin
            rsp_status_nxt = ffa_pkg::STAT_FAIL;
            rsp_id_nxt     = '0;
          end else if (is_erase) begin
            rsp_status_nxt = ffa_pkg::STAT_ILLEGAL;
            rsp_id_nxt     = '0;
          end
        end
      end
      ffa_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = next_id_r;
        idx_nxt   = idx_r + CW'(1);
        if (fill_last) begin
          rsp_status_nxt = ffa_pkg::STAT_OK;
          rsp_id_nxt     = next_id_ext[15:0];
          next_id_nxt    = next_id_r + ID_BITS'(1);
        end
      end
      ffa_pkg::ST_ZERO: begin
        mem_we     = 1'b1;
        mem_waddr  = wr_ptr_r[AW-1:0];
        wr_ptr_nxt = wr_ptr_r + CW'(1);
      end
      ffa_pkg::ST_RESP: begin
        // hold the result until the output register takes it
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ffa_pkg::ST_CLEAR;
      idx_r      <= '0;
      rd_valid_r <= 1'b0;
      run_r      <= '0;
      wr_ptr_r   <= '0;
      hit_r      <= 1'b0;
      op_r       <= ffa_pkg::OP_ALLOC;
      next_id_r  <= ID_BITS'(1);
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      rd_valid_r <= rd_valid_nxt;
      run_r      <= run_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      hit_r      <= hit_nxt;
      op_r       <= op_nxt;
      next_id_r  <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    req_r        <= req_nxt;
    id_r         <= id_nxt;
    rsp_status_r <= rsp_status_nxt;
    rsp_id_r     <= rsp_id_nxt;
  end

  assign stat.idle      = (state_r == ffa_pkg::ST_IDLE);
  assign stat.rsp_valid = (state_r == ffa_pkg::ST_RESP);
  assign rsp.status     = rsp_status_r;
  assign rsp.new_id     = rsp_id_r;

endmodule

`default_nettype wire

// ===== src/first_fit_allocator_with_compaction_core.sv =====
// Top level of the first-fit allocator: channels, size register, result register.
// Depends on ffa_pkg and ffa_engine.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  ffa_pkg::in_item_t
//   out_     output     out_valid/out_stall ffa_pkg::out_item_t
//   cfg      input      psel/penable/pready mem_size at byte address 0
//
// One item at a time; the owner-map memory port sets the pace, one cell a cycle.
// Allocate scans the first mem_size cells (at most MEM_CELLS), then fills request_size cells;
// erase scans all MEM_CELLS cells; defragment scans them all, then zeroes the tail.
// After reset a clearing pass zeroes every cell of the map; in_stall is high.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module first_fit_allocator_with_compaction_core #(
  parameter int MEM_CELLS = 128,
  parameter int ID_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ffa_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ffa_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffa_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0]             mem_size_r;
  logic                   out_valid_r;
  ffa_pkg::out_item_t     out_data_r;
  ffa_pkg::ffa_cmd_t      cmd;
  ffa_pkg::ffa_eng_stat_t eng_stat;
  ffa_pkg::out_item_t     eng_rsp;
  logic                   rsp_take;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == ffa_pkg::REG_MEM_SIZE) ? {24'd0, mem_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= ffa_pkg::MEM_SIZE_RESET;
    end else if (cfg_wr && (paddr[2] == ffa_pkg::REG_MEM_SIZE)) begin
      mem_size_r <= pwdata[7:0];
    end
  end

  assign in_stall  = !eng_stat.idle;
  assign cmd.start = in_valid && eng_stat.idle;
  assign cmd.item  = in_data;

  ffa_engine #(
    .MEM_CELLS (MEM_CELLS),
    .ID_BITS   (ID_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .mem_size (mem_size_r),
    .rsp_take (rsp_take),
    .stat     (eng_stat),
    .rsp      (eng_rsp)
  );

  // Load the output register whenever it is empty or being drained
  assign rsp_take = eng_stat.rsp_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_data_r <= eng_rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/ffa_checker.sv =====
// Port-level checks for the first-fit allocator core, bound to the top level.
// Depends on ffa_pkg for the item types and status codes.
`default_nettype none

module ffa_port_checks (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input ffa_pkg::out_item_t         out_data,
  input logic                       out_valid,
  input logic                       out_stall
);

  // A held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: an accepted item blocks the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // The clearing pass holds off input right after reset
  a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("input open before the map was cleared");

  // Failures and illegal erases carry no id
  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ffa_pkg::STAT_OK) |-> (out_data.new_id == 16'd0))
    else $error("failure result carries an id");

endmodule

bind first_fit_allocator_with_compaction_core ffa_port_checks u_ffa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire
